// File: hdl/tivr_pkg.sv
// Shared types, stage numbering and fixed-point constants for the vector rotator.
package tivr_pkg;

    // Field widths of the Q16.16 coordinates and angle, and of the Q2.16 tables.
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int TRIG_W   = 18;
    localparam int HALF_LSB = 2 ** (FRAC_W - 1);

    // Pipeline stages, in the order a request passes through them.
    localparam int NUM_STAGES  = 9;
    localparam int ST_WRAP_EST = 0;
    localparam int ST_WRAP_FIX = 1;
    localparam int ST_SCALE    = 2;
    localparam int ST_RECIP    = 3;
    localparam int ST_BASE     = 4;
    localparam int ST_ROM      = 5;
    localparam int ST_INTERP   = 6;
    localparam int ST_MUL      = 7;
    localparam int ST_OUT      = 8;

    // One turn is 360 * 2^16 = 45 * 2^19, so the low 19 bits of the angle pass
    // through and only the top 13 bits are reduced modulo 45.
    localparam int ANGLE_LO_W = 19;
    localparam int TURN_HI    = 45;
    localparam int HI_BIAS    = 4140;   // 92 * 45, lifts the signed top bits above zero
    localparam int HI_U_W     = 14;
    localparam int HI_RECIP   = 1456;   // just under 2^16 / 45
    localparam int HI_RECIP_W = 11;
    localparam int HI_SHIFT   = 16;
    localparam int HI_Q_W     = 8;
    localparam int REM_W      = 6;
    localparam int WRAP_W     = REM_W + ANGLE_LO_W;

    typedef logic [NUM_STAGES-1:0] t_stage_en;
    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        t_trig sin_base;
        t_trig sin_next;
        t_trig cos_base;
        t_trig cos_next;
    } t_trig_taps;

endpackage

// File: hdl/tivr_angle_index.sv
// Angle wrapping and table index generation: five pipeline stages.
module tivr_angle_index #(
    parameter int STEPS_PER_DEGREE = 4,
    parameter int TABLE_ENTRIES    = 1440
) (
    input  logic                                   i_clk,
    input  tivr_pkg::t_stage_en                    i_load,
    input  logic signed [tivr_pkg::DATA_W-1:0]     i_angle,
    output logic [$clog2(TABLE_ENTRIES)-1:0]       o_base,
    output logic [tivr_pkg::FRAC_W-1:0]            o_frac
);
    import tivr_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int STEPS_W = $clog2(STEPS_PER_DEGREE + 1);
    localparam int F_W     = WRAP_W + STEPS_W;
    localparam int V_W     = F_W - FRAC_W;
    localparam int RECIP   = (2 ** V_W) / TABLE_ENTRIES;
    localparam int RM_W    = V_W + IDX_W + 1;

    // Stage registers.
    logic [HI_U_W-1:0]     r_u;
    logic [HI_Q_W-1:0]     r_qhat;
    logic [ANGLE_LO_W-1:0] r_lo;
    logic [WRAP_W-1:0]     r_w;
    logic [V_W-1:0]        r_v_scale;
    logic [FRAC_W-1:0]     r_t_scale;
    logic [V_W-1:0]        r_qe;
    logic [V_W-1:0]        r_v_recip;
    logic [FRAC_W-1:0]     r_t_recip;
    logic [IDX_W-1:0]      r_base;
    logic [FRAC_W-1:0]     r_t_base;

    // Next values.
    logic signed [HI_U_W:0]          n_hi_biased;
    logic [HI_U_W+HI_RECIP_W-1:0]    n_qprod;
    logic [HI_U_W-1:0]               n_qmul;
    logic [HI_U_W-1:0]               n_rem_raw;
    logic [REM_W:0]                  n_rem;
    logic [REM_W:0]                  n_rem_fix;
    logic [F_W-1:0]                  n_scaled;
    logic [2*V_W-1:0]                n_rprod;
    logic [RM_W-1:0]                 n_qn;
    logic [RM_W-1:0]                 n_diff;
    logic [IDX_W:0]                  n_rem_idx;
    logic [IDX_W:0]                  n_base_fix;

    always_comb begin
        // Quotient estimate of the top bits by 45; it is low by at most one.
        n_hi_biased = (HI_U_W + 1)'(signed'(i_angle[DATA_W-1:ANGLE_LO_W]))
                    + (HI_U_W + 1)'(HI_BIAS);
        n_qprod     = (HI_U_W + HI_RECIP_W)'(n_hi_biased[HI_U_W-1:0])
                    * (HI_U_W + HI_RECIP_W)'(HI_RECIP);

        n_qmul      = HI_U_W'(r_qhat) * HI_U_W'(TURN_HI);
        n_rem_raw   = r_u - n_qmul;
        n_rem       = n_rem_raw[REM_W:0];
        n_rem_fix   = (n_rem >= (REM_W + 1)'(TURN_HI)) ? n_rem - (REM_W + 1)'(TURN_HI) : n_rem;

        n_scaled    = F_W'(r_w) * F_W'(STEPS_PER_DEGREE);

        n_rprod     = (2 * V_W)'(r_v_scale) * (2 * V_W)'(RECIP);

        // Remainder by the table size; the quotient estimate leaves it below twice that size.
        n_qn        = RM_W'(r_qe) * RM_W'(TABLE_ENTRIES);
        n_diff      = RM_W'(r_v_recip) - n_qn;
        n_rem_idx   = n_diff[IDX_W:0];
        n_base_fix  = (n_rem_idx >= (IDX_W + 1)'(TABLE_ENTRIES))
                    ? n_rem_idx - (IDX_W + 1)'(TABLE_ENTRIES) : n_rem_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_WRAP_EST]) begin
            r_u    <= n_hi_biased[HI_U_W-1:0];
            r_qhat <= n_qprod[HI_SHIFT +: HI_Q_W];
            r_lo   <= i_angle[ANGLE_LO_W-1:0];
        end
        if (i_load[ST_WRAP_FIX]) begin
            r_w <= {n_rem_fix[REM_W-1:0], r_lo};
        end
        if (i_load[ST_SCALE]) begin
            r_v_scale <= n_scaled[F_W-1:FRAC_W];
            r_t_scale <= n_scaled[FRAC_W-1:0];
        end
        if (i_load[ST_RECIP]) begin
            r_qe      <= n_rprod[2*V_W-1:V_W];
            r_v_recip <= r_v_scale;
            r_t_recip <= r_t_scale;
        end
        if (i_load[ST_BASE]) begin
            r_base   <= n_base_fix[IDX_W-1:0];
            r_t_base <= r_t_recip;
        end
    end

    assign o_base = r_base;
    assign o_frac = r_t_base;

endmodule

// File: hdl/tivr_trig_rom.sv
// Sine and cosine ROMs, each read at the base entry and the one after it.
module tivr_trig_rom #(
    parameter int STEPS_PER_DEGREE = 4,
    parameter int TABLE_ENTRIES    = 1440
) (
    input  logic                             i_clk,
    input  tivr_pkg::t_stage_en              i_load,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_base,
    output tivr_pkg::t_trig_taps             o_taps
);
    import tivr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [63:0] QUARTER    = 64'(90 * STEPS_PER_DEGREE);
    localparam logic [63:0] TURN_STEPS = 64'(360 * STEPS_PER_DEGREE);
    localparam logic [63:0] RAD_DIV    = 64'(180 * STEPS_PER_DEGREE);
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DIVS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef t_trig t_rom [TABLE_ENTRIES];

    // Sine of one table step: first quadrant folded, Horner-form series in Q30,
    // rounded to Q16 and negated in the lower half-turn.
    function automatic t_trig sine_of_step(input logic [63:0] step);
        logic [63:0] j;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        t_trig       mag;
        j = step % TURN_STEPS;
        q = j / QUARTER;
        r = j % QUARTER;
        if (q[0]) begin
            r = QUARTER - r;
        end
        x  = (r * PI_Q30) / RAD_DIV;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int k = 0; k < 6; k++) begin
            t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIVS[k]);
        end
        s   = (x * t) >> 30;
        s   = (s + (64'd1 << 13)) >> 14;
        mag = TRIG_W'(s);
        return (q >= 64'd2) ? -mag : mag;
    endfunction

    function automatic t_rom build_rom(input logic cosine);
        t_rom rom;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            rom[i] = sine_of_step(64'(i) + (cosine ? QUARTER : 64'd0));
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = build_rom(1'b0);
    localparam t_rom COS_ROM = build_rom(1'b1);

    logic [IDX_W-1:0] n_next;
    t_trig_taps       r_taps;

    assign n_next = (i_base == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : i_base + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_load[ST_ROM]) begin
            r_taps.sin_base <= SIN_ROM[i_base];
            r_taps.sin_next <= SIN_ROM[n_next];
            r_taps.cos_base <= COS_ROM[i_base];
            r_taps.cos_next <= COS_ROM[n_next];
        end
    end

    assign o_taps = r_taps;

endmodule

// File: hdl/tivr_rotate.sv
// Linear interpolation of the table taps and the rotation matrix with rounding and saturation.
module tivr_rotate (
    input  logic                               i_clk,
    input  tivr_pkg::t_stage_en                i_load,
    input  tivr_pkg::t_trig_taps               i_taps,
    input  logic [tivr_pkg::FRAC_W-1:0]        i_frac,
    input  logic signed [tivr_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [tivr_pkg::DATA_W-1:0] i_vec_y,
    output logic signed [tivr_pkg::DATA_W-1:0] o_rot_x,
    output logic signed [tivr_pkg::DATA_W-1:0] o_rot_y
);
    import tivr_pkg::*;

    localparam int MIX_W  = TRIG_W + FRAC_W + 3;
    localparam int PROD_W = DATA_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam longint SAT_HI = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam longint SAT_LO = -(64'sd1 <<< (DATA_W - 1));

    // a + w * (b - a), which equals (1 - w) * a + w * b exactly, rounded to Q2.16.
    function automatic t_trig interp(input t_trig a, input t_trig b, input logic [FRAC_W-1:0] w);
        logic signed [TRIG_W:0]  d;
        logic signed [MIX_W-1:0] acc;
        d   = (TRIG_W + 1)'(b) - (TRIG_W + 1)'(a);
        acc = (MIX_W'(a) <<< FRAC_W)
            + MIX_W'(d) * MIX_W'(signed'({1'b0, w}))
            + MIX_W'(HALF_LSB);
        return TRIG_W'(acc >>> FRAC_W);
    endfunction

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] sh;
        sh = (v + SUM_W'(HALF_LSB)) >>> FRAC_W;
        priority if (sh > SUM_W'(SAT_HI)) begin
            return DATA_W'(SAT_HI);
        end else if (sh < SUM_W'(SAT_LO)) begin
            return DATA_W'(SAT_LO);
        end else begin
            return DATA_W'(sh);
        end
    endfunction

    t_trig                    r_cos;
    t_trig                    r_sin;
    logic signed [DATA_W-1:0] r_vx;
    logic signed [DATA_W-1:0] r_vy;
    logic signed [PROD_W-1:0] r_pxc;
    logic signed [PROD_W-1:0] r_pys;
    logic signed [PROD_W-1:0] r_pxs;
    logic signed [PROD_W-1:0] r_pyc;
    logic signed [DATA_W-1:0] r_rot_x;
    logic signed [DATA_W-1:0] r_rot_y;

    logic signed [SUM_W-1:0]  n_sum_x;
    logic signed [SUM_W-1:0]  n_sum_y;

    assign n_sum_x = SUM_W'(r_pxc) - SUM_W'(r_pys);
    assign n_sum_y = SUM_W'(r_pxs) + SUM_W'(r_pyc);

    always_ff @(posedge i_clk) begin
        if (i_load[ST_INTERP]) begin
            r_cos <= interp(i_taps.cos_base, i_taps.cos_next, i_frac);
            r_sin <= interp(i_taps.sin_base, i_taps.sin_next, i_frac);
            r_vx  <= i_vec_x;
            r_vy  <= i_vec_y;
        end
        if (i_load[ST_MUL]) begin
            r_pxc <= PROD_W'(r_vx) * PROD_W'(r_cos);
            r_pys <= PROD_W'(r_vy) * PROD_W'(r_sin);
            r_pxs <= PROD_W'(r_vx) * PROD_W'(r_sin);
            r_pyc <= PROD_W'(r_vy) * PROD_W'(r_cos);
        end
        if (i_load[ST_OUT]) begin
            r_rot_x <= round_sat(n_sum_x);
            r_rot_y <= round_sat(n_sum_y);
        end
    end

    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_rot_y;

endmodule

// File: hdl/table_interp_vector_rotator.sv
// o_valid rises once an accepted request has passed through every stage register,
// and the result leaves on an edge at which i_stall is low.
// Throughput: one request per cycle when i_stall is low, set by the nine-stage pipeline
// and the two read ports of each sine and cosine ROM, read once per request in stage 5.
// Reset (synchronous, active low) clears only the stage valid bits; the ROMs are
// constants built at elaboration and need no clearing pass.
module table_interp_vector_rotator #(
    parameter int STEPS_PER_DEGREE = 4,
    parameter int TABLE_ENTRIES    = 1440
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [tivr_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [tivr_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [tivr_pkg::DATA_W-1:0] i_angle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [tivr_pkg::DATA_W-1:0] o_rot_x,
    output logic signed [tivr_pkg::DATA_W-1:0] o_rot_y
);
    import tivr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // Pipeline control. Each stage keeps a valid bit and loads whenever it is
    // empty or the stage after it is loading, so bubbles are squeezed out and a
    // new request is taken even while a finished result waits at the output.
    t_stage_en r_vld;
    t_stage_en n_vld;
    t_stage_en load;

    always_comb begin
        load[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
        n_vld[0] = load[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = load[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !load[0];
    assign o_valid = r_vld[ST_OUT];

    // The vector components ride alongside the angle path until the table
    // taps are ready, and then enter the rotation stages together with them.
    logic signed [DATA_W-1:0] r_vec_x [ST_ROM+1];
    logic signed [DATA_W-1:0] r_vec_y [ST_ROM+1];
    logic [FRAC_W-1:0]        r_frac_rom;

    logic [IDX_W-1:0]  base;
    logic [FRAC_W-1:0] frac;
    t_trig_taps        taps;

    always_ff @(posedge i_clk) begin
        if (load[ST_WRAP_EST]) begin
            r_vec_x[0] <= i_vec_x;
            r_vec_y[0] <= i_vec_y;
        end
        for (int k = 1; k <= ST_ROM; k++) begin
            if (load[k]) begin
                r_vec_x[k] <= r_vec_x[k-1];
                r_vec_y[k] <= r_vec_y[k-1];
            end
        end
        if (load[ST_ROM]) begin
            r_frac_rom <= frac;
        end
    end

    // Stages 0 to 4: wrap the angle into one turn, scale to table steps and
    // reduce the step number to a table index plus a 16-bit weight.
    tivr_angle_index #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE),
        .TABLE_ENTRIES    (TABLE_ENTRIES)
    ) u_angle (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_angle (i_angle),
        .o_base  (base),
        .o_frac  (frac)
    );

    // Stage 5: registered reads of both ROMs at the index and its wrapped successor.
    tivr_trig_rom #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE),
        .TABLE_ENTRIES    (TABLE_ENTRIES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_load (load),
        .i_base (base),
        .o_taps (taps)
    );

    // Stages 6 to 8: interpolate sine and cosine, form the four products, then
    // round and saturate the two rotated components into the output register.
    tivr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_taps  (taps),
        .i_frac  (r_frac_rom),
        .i_vec_x (r_vec_x[ST_ROM]),
        .i_vec_y (r_vec_y[ST_ROM]),
        .o_rot_x (o_rot_x),
        .o_rot_y (o_rot_y)
    );

    // The input is only held off when every stage holds a request.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while the pipeline has an empty stage");

    // The index reduction must always land inside the table.
    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_BASE] |-> ((IDX_W + 1)'(base) < (IDX_W + 1)'(TABLE_ENTRIES)))
        else $error("table index out of range");

    // An accepted request occupies the first stage on the next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[ST_WRAP_EST])
        else $error("accepted request lost at the first stage");

    // A result that moves out of the multiply stage while the output loads must appear.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_MUL] && load[ST_OUT]) |=> o_valid)
        else $error("result lost entering the output register");

endmodule

// File: dv/table_interp_vector_rotator_test.sv
// Self-checking testbench for the table-interpolated vector rotator.
`timescale 1ns / 100ps

module table_interp_vector_rotator_test;

    import tivr_pkg::*;

    // The block is built with its default table geometry.
    localparam int STEPS_PER_DEG = 4;
    localparam int TRIG_ENTRIES  = 1440;

    // Fixed-point constants of the angle path and of the table build.
    localparam int             ONE_DEG     = 65536;
    localparam longint         FULL_TURN   = 360 * 65536;
    localparam longint unsigned PI_IN_Q30  = 64'd3373259426;
    localparam longint unsigned UNIT_Q30   = 64'd1 << 30;
    localparam logic signed [DATA_W-1:0] POS_LIMIT = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] NEG_LIMIT = 32'sh8000_0000;

    // Run control: the slack after draining covers the nine-stage pipeline
    // with room to spare, and the cycle limit is far above the slowest run.
    localparam int DRAIN_SLACK = 40;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 430;

    typedef struct {
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] angle;
    } t_request;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_rotated;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     i_valid  = 1'b0;
    logic                     i_stall  = 1'b0;
    logic signed [DATA_W-1:0] i_vec_x  = '0;
    logic signed [DATA_W-1:0] i_vec_y  = '0;
    logic signed [DATA_W-1:0] i_angle  = '0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_rot_x;
    logic signed [DATA_W-1:0] o_rot_y;

    // Our own copies of the sine and cosine tables, filled before reset ends.
    t_trig sin_tab [TRIG_ENTRIES];
    t_trig cos_tab [TRIG_ENTRIES];

    // Requests waiting to be offered, and rotations waiting to come out.
    t_request pending_requests [$];
    t_rotated expected_rot [$];

    // Traffic shaping, set by the stimulus process between phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_cnt   = 0;
    int hold_req_seen  = 0;
    int hold_left      = 0;

    int cycle_count  = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_saturated  = 0;
    int n_errors     = 0;

    bit       offering;
    t_request next_req;
    t_rotated want;

    table_interp_vector_rotator #(
        .STEPS_PER_DEGREE(STEPS_PER_DEG),
        .TABLE_ENTRIES   (TRIG_ENTRIES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_vec_x(i_vec_x),
        .i_vec_y(i_vec_y),
        .i_angle(i_angle),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rot_x(o_rot_x),
        .o_rot_y(o_rot_y)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Sine of table step n, in Q2.16. The angle is folded into the first
    // quadrant, a Horner-form Taylor series up to the thirteenth power is
    // worked in unsigned Q30 with truncation after every product and every
    // division, and the result is rounded to sixteen fraction bits.
    function automatic longint sine_at_step(input longint unsigned step);
        longint unsigned quarter;
        longint unsigned folded;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x_sq;
        longint unsigned series;
        longint unsigned value;
        longint unsigned divisors [6];
        divisors = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        quarter = 64'd90 * STEPS_PER_DEG;
        folded  = step % (64'd4 * quarter);
        quad    = folded / quarter;
        rem     = folded % quarter;
        if (quad[0]) begin
            rem = quarter - rem;
        end
        x      = (rem * PI_IN_Q30) / (64'd180 * STEPS_PER_DEG);
        x_sq   = (x * x) >> 30;
        series = UNIT_Q30;
        for (int k = 0; k < 6; k++) begin
            series = UNIT_Q30 - ((x_sq * series) >> 30) / divisors[k];
        end
        value = (x * series) >> 30;
        value = (value + (64'd1 << 13)) >> 14;
        return (quad >= 2) ? -longint'(value) : longint'(value);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
        if (v > longint'(POS_LIMIT)) begin
            return POS_LIMIT;
        end
        if (v < longint'(NEG_LIMIT)) begin
            return NEG_LIMIT;
        end
        return v[DATA_W-1:0];
    endfunction

    // Rotation that the block should produce for one request. The angle is
    // wrapped by a true modulo, scaled to table steps, and the two entries
    // either side of it are blended by the sixteen-bit fraction.
    function automatic t_rotated rotate_expected(input t_request req);
        longint   wrapped;
        longint   steps_q16;
        longint   frac;
        longint   cos_w;
        longint   sin_w;
        int       base;
        int       succ;
        t_rotated res;
        wrapped = longint'(req.angle) % FULL_TURN;
        if (wrapped < 0) begin
            wrapped += FULL_TURN;
        end
        steps_q16 = wrapped * STEPS_PER_DEG;
        base      = int'((steps_q16 >>> FRAC_W) % TRIG_ENTRIES);
        frac      = steps_q16 & 64'hFFFF;
        succ      = (base + 1) % TRIG_ENTRIES;
        cos_w = ((65536 - frac) * longint'(cos_tab[base])
                 + frac * longint'(cos_tab[succ]) + HALF_LSB) >>> FRAC_W;
        sin_w = ((65536 - frac) * longint'(sin_tab[base])
                 + frac * longint'(sin_tab[succ]) + HALF_LSB) >>> FRAC_W;
        res.x = clamp_q16((longint'(req.vec_x) * cos_w - longint'(req.vec_y) * sin_w
                           + HALF_LSB) >>> FRAC_W);
        res.y = clamp_q16((longint'(req.vec_x) * sin_w + longint'(req.vec_y) * cos_w
                           + HALF_LSB) >>> FRAC_W);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        $display("mismatch at cycle %0d: %s got %h expected %h",
                 cycle_count, what, got, exp_val);
        n_errors++;
    endtask

    // Driver. A request whose handshake completes at this edge is predicted
    // at once; then, unless the current request is still held by a stall,
    // the next pending request is offered or the sender idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offering = i_valid;
            if (i_valid && !o_stall) begin
                next_req.vec_x = i_vec_x;
                next_req.vec_y = i_vec_y;
                next_req.angle = i_angle;
                expected_rot.push_back(rotate_expected(next_req));
                n_accepted++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    i_valid <= 1'b1;
                    i_vec_x <= next_req.vec_x;
                    i_vec_y <= next_req.vec_y;
                    i_angle <= next_req.angle;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure. A long hold-off, once asked for, is counted
    // down here while the sender keeps offering; otherwise the stall is drawn
    // at random at the rate of the current phase.
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_req_seen) begin
            hold_req_seen <= hold_req_cnt;
            hold_left     <= LONG_HOLD;
            i_stall       <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: every result taken is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_rot.size() == 0) begin
                report_mismatch("result with no request outstanding", o_rot_x, '0);
            end else begin
                want = expected_rot.pop_front();
                if (o_rot_x !== want.x) begin
                    report_mismatch("rot_x", o_rot_x, want.x);
                end
                if (o_rot_y !== want.y) begin
                    report_mismatch("rot_y", o_rot_y, want.y);
                end
                if (want.x == POS_LIMIT || want.x == NEG_LIMIT ||
                    want.y == POS_LIMIT || want.y == NEG_LIMIT) begin
                    n_saturated++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d rotations outstanding",
                     cycle_count, expected_rot.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_request(input logic signed [DATA_W-1:0] vx,
                                 input logic signed [DATA_W-1:0] vy,
                                 input logic signed [DATA_W-1:0] ang);
        t_request req;
        req.vec_x = vx;
        req.vec_y = vy;
        req.angle = ang;
        pending_requests.push_back(req);
    endtask

    // Random request. Four in ten draw every bit of every field at random;
    // the rest keep vectors small enough not to saturate, put the angle on
    // or near a quadrant boundary and the table wrap, or within a turn of zero.
    task automatic queue_random_request();
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] ang;
        int unsigned              shape;
        vx    = $urandom;
        vy    = $urandom;
        ang   = $urandom;
        shape = $urandom_range(9);
        if (shape < 3) begin
            vx = $signed(vx) >>> $urandom_range(31, 8);
            vy = $signed(vy) >>> $urandom_range(31, 8);
        end
        if (shape == 3 || shape == 4) begin
            ang = $signed($urandom_range(16) * 90 - 720) * ONE_DEG
                  + $signed($urandom_range(32)) - 16;
        end else if (shape == 5) begin
            ang = DATA_W'(longint'($urandom_range(32'(2 * FULL_TURN))) - FULL_TURN);
        end
        queue_request(vx, vy, ang);
    endtask

    // Sets the idling rates of a phase, in the sender and the receiver.
    task automatic set_traffic(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Holds the stimulus back until every request has gone in and every
    // rotation has come out, so the next phase starts from an empty pipe.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_rot.size() != 0 || i_valid) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        for (int n = 0; n < TRIG_ENTRIES; n++) begin
            sin_tab[n] = t_trig'(sine_at_step(64'(n)));
            cos_tab[n] = t_trig'(sine_at_step(64'(n + 90 * STEPS_PER_DEG)));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests: the quadrant angles, one full turn, negative
        // and extreme angles, the last step before the table wraps, the
        // largest interpolation fraction, and vectors that saturate both ways.
        set_traffic(0, 0);
        queue_request(32'sh0001_0000, 32'sh0000_0000, 0);
        queue_request(32'sh0001_0000, 32'sh0000_0000, 90 * ONE_DEG);
        queue_request(32'sh0001_0000, 32'sh0002_0000, 180 * ONE_DEG);
        queue_request(32'sh0003_0000, 32'sh0001_0000, 270 * ONE_DEG);
        queue_request(32'sh0001_0000, 32'sh0001_0000, 360 * ONE_DEG);
        queue_request(32'sh0001_0000, -32'sh0001_0000, -90 * ONE_DEG);
        queue_request(32'sh0001_0000, 32'sh0000_8000, -1);
        queue_request(32'sh0001_0000, 32'sh0000_0000, 360 * ONE_DEG - 1);
        queue_request(32'sh0001_0000, 32'sh0000_0000, 359 * ONE_DEG + 49152);
        queue_request(32'sh0005_0000, 32'sh0007_0000, 30 * ONE_DEG + 16383);
        queue_request(32'sh0000_0001, 32'sh0000_0001, POS_LIMIT);
        queue_request(-32'sh0000_0001, 32'sh0000_0001, NEG_LIMIT);
        queue_request(POS_LIMIT, POS_LIMIT, 45 * ONE_DEG);
        queue_request(NEG_LIMIT, NEG_LIMIT, 45 * ONE_DEG);
        queue_request(POS_LIMIT, NEG_LIMIT, 45 * ONE_DEG);
        queue_request(NEG_LIMIT, POS_LIMIT, 135 * ONE_DEG);
        queue_request(POS_LIMIT, 32'sh0000_0000, 180 * ONE_DEG);
        queue_request(NEG_LIMIT, 32'sh0000_0000, 180 * ONE_DEG);
        queue_request(32'sh0000_0000, NEG_LIMIT, 270 * ONE_DEG);
        queue_request(32'sh0000_0000, 32'sh0000_0000, 123 * ONE_DEG + 777);
        queue_request(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        queue_request(POS_LIMIT, POS_LIMIT, POS_LIMIT);
        wait_drained();

        // Random traffic under each idling pattern in turn.
        set_traffic(0, 0);
        repeat (PHASE_ITEMS) queue_random_request();
        wait_drained();

        set_traffic(75, 0);
        repeat (PHASE_ITEMS) queue_random_request();
        wait_drained();

        set_traffic(0, 75);
        repeat (PHASE_ITEMS) queue_random_request();
        wait_drained();

        set_traffic(29, 29);
        repeat (PHASE_ITEMS) queue_random_request();
        wait_drained();

        // Back-pressure burst: the receiver holds off for a long stretch
        // while the sender offers every cycle, so the pipe fills and stalls.
        set_traffic(0, 0);
        hold_req_cnt++;
        repeat (60) queue_random_request();
        wait_drained();

        set_traffic(0, 0);
        repeat (DRAIN_SLACK) @(negedge i_clk);

        $display("rotated %0d requests (directed, four idling patterns, one long hold-off)",
                 n_accepted);
        $display("checked %0d results, %0d of them saturated, %0d mismatches",
                 n_results, n_saturated, n_errors);
        if (n_errors == 0 && expected_rot.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
